[rtl/core/isj_pkg.sv]
`timescale 1ns / 1ps

package isj_pkg;

	// Build-time sizing of the key store and counters.
	localparam int DEPTH      = 64;
	localparam int INDEX_BITS = 10;
	localparam int PROBE_BITS = 16;

	// Fixed widths of the beat fields.
	localparam int IDX_W    = 10;
	localparam int FIRST_W  = 16;
	localparam int SECOND_W = 6;

	localparam int KEY_W = 3 * INDEX_BITS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);

	typedef logic [KEY_W-1:0] key_t;
	typedef logic [AW-1:0]    slot_t;

	typedef enum logic [1:0] {
		REQ_LOAD  = 2'd0,
		REQ_PROBE = 2'd1,
		REQ_FLUSH = 2'd2,
		REQ_NONE  = 2'd3
	} req_e_t;

	typedef enum logic [1:0] {
		KIND_PAIR    = 2'd0,
		KIND_FIRST   = 2'd1,
		KIND_SECOND  = 2'd2,
		KIND_EMPTY   = 2'd3
	} kind_e_t;

	// Probe token that walks the cell row, collecting the highest matching slot.
	typedef struct packed {
		logic  vld;
		key_t  key;
		logic  hit;
		slot_t where;
	} tok_t;

	// Control broadcast from the sequencer to every cell.
	typedef struct packed {
		logic  wr;
		slot_t wr_idx;
		key_t  wr_key;
		logic  mark_set;
		slot_t mark_idx;
		logic  clear;
	} cell_ctl_t;

endpackage

[rtl/core/index_set_join.sv]
`timescale 1ns / 1ps
// A load beat takes effect at the edge that accepts it, and the input does not stall for it,
// so load beats can be accepted back to back. A probe beat walks the row of DEPTH cells one cell
// per cycle; the input stalls until its result beat has entered the output register, so a new
// probe is not accepted before the last one is through. A flush scans one slot per cycle in which the
// output is free and emits one beat per unmarked entry (or one empty beat).
// Reset (asynchronous, active low) clears counters, marks, valid bits and the overflow flag.
module index_set_join
	import isj_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,

	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 req_type,
	input  logic signed [IDX_W-1:0]    idx_h,
	input  logic signed [IDX_W-1:0]    idx_k,
	input  logic signed [IDX_W-1:0]    idx_l,

	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [1:0]                 kind,
	output logic [FIRST_W-1:0]         first_number,
	output logic [SECOND_W-1:0]        second_number,
	output logic                       overflow,
	output logic                       last
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_PROBE,
		S_PRES,
		S_FLUSH
	} state_t;

	state_t                state_q;
	logic [CW-1:0]         cnt_q;
	logic [PROBE_BITS-1:0] probe_q;
	logic [PROBE_BITS-1:0] num_q;
	logic                  ovf_q;
	logic                  hit_q;
	slot_t                 where_q;
	slot_t                 scan_q;
	logic                  launch_vld_q;
	key_t                  launch_key_q;

	logic                  out_valid_q;
	logic [1:0]            kind_q;
	logic [FIRST_W-1:0]    first_q;
	logic [SECOND_W-1:0]   second_q;
	logic                  ovf_out_q;
	logic                  last_q;

	// Token chain: entry 0 comes from the launch registers, entry DEPTH is the exit of the
	// last cell.
	tok_t                  toks [DEPTH+1];
	logic [DEPTH-1:0]      unm;
	cell_ctl_t             ctl;

	key_t                  key_in;
	logic                  accept;
	logic                  out_free;
	logic                  emit;
	logic                  store_full;
	logic [DEPTH-1:0]      le_mask;
	logic [DEPTH-1:0]      upper;
	logic                  flush_done;

	// Only the low INDEX_BITS of each component take part; narrow or sign-extend.
	assign key_in = {INDEX_BITS'(idx_l), INDEX_BITS'(idx_k), INDEX_BITS'(idx_h)};

	assign in_stall   = (state_q != S_IDLE);
	assign accept     = in_valid && !in_stall;
	assign out_free   = !out_valid_q || !out_stall;
	assign store_full = (cnt_q >= CW'(DEPTH));

	// Unmarked entries above the current scan slot decide whether this beat is the last.
	assign le_mask = ((DEPTH'(1) << scan_q) << 1) - DEPTH'(1);
	assign upper   = unm & ~le_mask;

	assign flush_done = (state_q == S_FLUSH) && out_free &&
	                    ((unm == '0) || (unm[scan_q] && (upper == '0)));

	// A new result beat enters the output register in this cycle.
	assign emit = out_free && ((state_q == S_PRES) ||
	              ((state_q == S_FLUSH) && ((unm == '0) || unm[scan_q])));

	always_comb begin
		ctl          = '0;
		ctl.wr       = accept && (req_e_t'(req_type) == REQ_LOAD) && !store_full;
		ctl.wr_idx   = cnt_q[AW-1:0];
		ctl.wr_key   = key_in;
		ctl.mark_set = (state_q == S_PRES) && out_free && hit_q;
		ctl.mark_idx = where_q;
		ctl.clear    = flush_done;
	end

	assign toks[0] = '{vld: launch_vld_q, key: launch_key_q, hit: 1'b0, where: '0};

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		isj_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (AW'(i)),
			.ctl      (ctl),
			.tok_in   (toks[i]),
			.tok_out  (toks[i+1]),
			.unmarked (unm[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			probe_q      <= '0;
			num_q        <= '0;
			ovf_q        <= 1'b0;
			hit_q        <= 1'b0;
			where_q      <= '0;
			scan_q       <= '0;
			launch_vld_q <= 1'b0;
			launch_key_q <= '0;
			out_valid_q  <= 1'b0;
			kind_q       <= '0;
			first_q      <= '0;
			second_q     <= '0;
			ovf_out_q    <= 1'b0;
			last_q       <= 1'b0;
		end else begin
			launch_vld_q <= accept && (req_e_t'(req_type) == REQ_PROBE);
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (req_e_t'(req_type))
							REQ_LOAD: begin
								// A load into a full store is dropped and flagged.
								if (store_full) begin
									ovf_q <= 1'b1;
								end else begin
									cnt_q <= cnt_q + CW'(1);
								end
							end
							REQ_PROBE: begin
								num_q <= probe_q;
								// The counter saturates; the flag is set before the result forms.
								if (probe_q == {PROBE_BITS{1'b1}}) begin
									ovf_q <= 1'b1;
								end else begin
									probe_q <= probe_q + PROBE_BITS'(1);
								end
								launch_key_q <= key_in;
								state_q      <= S_PROBE;
							end
							REQ_FLUSH: begin
								scan_q  <= '0;
								state_q <= S_FLUSH;
							end
							REQ_NONE: begin
							end
							default: begin
							end
						endcase
					end
				end

				S_PROBE: begin
					// The token leaves the last cell carrying the newest matching slot.
					if (toks[DEPTH].vld) begin
						hit_q   <= toks[DEPTH].hit;
						where_q <= toks[DEPTH].where;
						state_q <= S_PRES;
					end
				end

				S_PRES: begin
					if (out_free) begin
						kind_q    <= hit_q ? KIND_PAIR : KIND_FIRST;
						first_q   <= FIRST_W'(num_q);
						second_q  <= hit_q ? SECOND_W'(where_q) : '0;
						ovf_out_q <= ovf_q;
						last_q    <= 1'b1;
						state_q   <= S_IDLE;
					end
				end

				S_FLUSH: begin
					if (out_free) begin
						if (unm == '0) begin
							// Nothing left unmatched: a single empty beat closes the flush.
							kind_q    <= KIND_EMPTY;
							first_q   <= '0;
							second_q  <= '0;
							ovf_out_q <= ovf_q;
							last_q    <= 1'b1;
						end else if (unm[scan_q]) begin
							kind_q    <= KIND_SECOND;
							first_q   <= '0;
							second_q  <= SECOND_W'(scan_q);
							ovf_out_q <= ovf_q;
							last_q    <= (upper == '0);
							scan_q    <= scan_q + AW'(1);
						end else begin
							scan_q <= scan_q + AW'(1);
						end

						// Flush beats report the flag as it stood before the clear.
						if (flush_done) begin
							cnt_q   <= '0;
							probe_q <= '0;
							ovf_q   <= 1'b0;
							state_q <= S_IDLE;
						end
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = kind_q;
	assign first_number  = first_q;
	assign second_number = second_q;
	assign overflow      = ovf_out_q;
	assign last          = last_q;

endmodule

[rtl/core/isj_cell.sv]
`timescale 1ns / 1ps

module isj_cell
	import isj_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  slot_t     cell_idx,
	input  cell_ctl_t ctl,
	input  tok_t      tok_in,
	output tok_t      tok_out,
	output logic      unmarked
);

	key_t key_q;
	logic used_q;
	logic mark_q;
	tok_t tok_s1;
	tok_t tok_nxt;
	logic sel_wr;
	logic sel_mark;

	assign sel_wr   = ctl.wr && (ctl.wr_idx == cell_idx);
	assign sel_mark = ctl.mark_set && (ctl.mark_idx == cell_idx);

	// A later cell overrides an earlier hit, so the newest equal key wins.
	always_comb begin
		tok_nxt = tok_in;
		if (tok_in.vld && used_q && (tok_in.key == key_q)) begin
			tok_nxt.hit   = 1'b1;
			tok_nxt.where = cell_idx;
		end
	end

	always_ff @(posedge clk) begin
		if (sel_wr) begin
			key_q <= ctl.wr_key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			mark_q <= 1'b0;
			tok_s1 <= '0;
		end else begin
			if (ctl.clear) begin
				used_q <= 1'b0;
				mark_q <= 1'b0;
			end else if (sel_wr) begin
				used_q <= 1'b1;
				mark_q <= 1'b0;
			end else if (sel_mark) begin
				mark_q <= 1'b1;
			end

			tok_s1 <= tok_nxt;
		end
	end

	assign tok_out  = tok_s1;
	assign unmarked = used_q & ~mark_q;

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

// Self-checking bench for the index set join. A queue of requests, filled once
// at time zero, feeds a clocked driver that offers them in bursts. A clocked
// monitor runs every accepted request through a behavioral copy of the join.
// That copy covers the key store, the match marks, the probe counter and the
// sticky overflow flag. The monitor then checks each result beat in order
// against the beats that the copy predicted.
module tb;
	import isj_pkg::*;

	localparam int PERIOD     = 10;
	localparam int RAND_ITEMS = 60;
	// Longest quiet stretch the run tolerates. It covers the receiver's long
	// hold-off and the widest sender gap, with a probe trip down the row on top.
	localparam int IDLE_LIMIT = 4000;
	// The long receiver hold-off starts once this many result beats have gone by.
	localparam int HOLD_BEAT  = 90;
	localparam int HOLD_LEN   = 400;

	typedef struct packed {
		logic signed [IDX_W-1:0] h;
		logic signed [IDX_W-1:0] k;
		logic signed [IDX_W-1:0] l;
	} triple_t;

	typedef struct packed {
		req_e_t  req;
		triple_t idx;
		logic    after_drain;	// hold this request back until every result is in
	} request_t;

	typedef struct packed {
		kind_e_t             kind;
		logic [FIRST_W-1:0]  first;
		logic [SECOND_W-1:0] second;
		logic                ovf;
		logic                lst;
	} join_beat_t;

	typedef enum {RX_FREE, RX_COIN, RX_THREE_OF_FOUR, RX_SPARSE} rx_pattern_t;

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    in_valid  = 1'b0;
	logic                    in_stall;
	logic [1:0]              req_type  = REQ_NONE;
	logic signed [IDX_W-1:0] idx_h     = '0;
	logic signed [IDX_W-1:0] idx_k     = '0;
	logic signed [IDX_W-1:0] idx_l     = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [1:0]              kind;
	logic [FIRST_W-1:0]      first_number;
	logic [SECOND_W-1:0]     second_number;
	logic                    overflow;
	logic                    last;

	index_set_join DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.idx_h        (idx_h),
		.idx_k        (idx_k),
		.idx_l        (idx_l),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.first_number (first_number),
		.second_number(second_number),
		.overflow     (overflow),
		.last         (last)
	);

	always #(PERIOD / 2) clk = ~clk;

	// Behavioral copy of the join state. Its values after reset match the block's.
	key_t                  store_keys [DEPTH] = '{default: '0};
	bit                    store_hit  [DEPTH] = '{default: 1'b0};
	int unsigned           store_fill = 0;
	logic [PROBE_BITS-1:0] probe_num  = '0;
	bit                    ovf_sticky = 1'b0;

	join_beat_t join_results_due [$];
	request_t   requests_to_send [$];

	int       queued      = 0;	// requests other than the ignored code
	int       errors      = 0;
	int       idle_cycles = 0;
	int       out_beats   = 0;
	request_t on_port     = '0;	// request currently presented on the input
	bit       in_taken    = 1'b0;

	// Applies one accepted request to the copy of the state. It appends the
	// result beats that the request causes to join_results_due.
	function automatic void match_and_emit(request_t rq);
		key_t        key;
		bit          hit;
		int unsigned where;
		int unsigned i;
		int          n_out;
		join_beat_t  b;
		key   = {rq.idx.l[INDEX_BITS-1:0], rq.idx.k[INDEX_BITS-1:0],
			rq.idx.h[INDEX_BITS-1:0]};
		hit   = 1'b0;
		where = 0;
		n_out = 0;
		b     = '0;
		case (rq.req)
			REQ_LOAD: begin
				// A load into a full store is dropped and only raises the flag.
				if (store_fill >= DEPTH) begin
					ovf_sticky = 1'b1;
				end else begin
					store_keys[store_fill] = key;
					store_hit[store_fill]  = 1'b0;
					store_fill++;
				end
			end
			REQ_PROBE: begin
				// With duplicate keys, the entry loaded last is the one that matches.
				for (i = 0; i < store_fill; i++) begin
					if (store_keys[i] == key) begin
						hit   = 1'b1;
						where = i;
					end
				end
				// A saturated counter raises the flag before the beat is formed.
				b.first = FIRST_W'(probe_num);
				if (&probe_num) begin
					ovf_sticky = 1'b1;
				end else begin
					probe_num++;
				end
				b.ovf = ovf_sticky;
				b.lst = 1'b1;
				if (hit) begin
					store_hit[where] = 1'b1;
					b.kind   = KIND_PAIR;
					b.second = SECOND_W'(where);
				end else begin
					b.kind = KIND_FIRST;
				end
				join_results_due = {join_results_due, b};
			end
			REQ_FLUSH: begin
				// Flush beats carry the flag as it stood before the clear.
				b.ovf  = ovf_sticky;
				b.kind = KIND_SECOND;
				for (i = 0; i < store_fill; i++) begin
					if (!store_hit[i]) begin
						b.second = SECOND_W'(i);
						join_results_due = {join_results_due, b};
						n_out++;
					end
				end
				if (n_out == 0) begin
					b.kind = KIND_EMPTY;
					b.lst  = 1'b1;
				end else begin
					b = join_results_due.pop_back();
					b.lst = 1'b1;
				end
				join_results_due = {join_results_due, b};
				for (i = 0; i < DEPTH; i++) begin
					store_hit[i] = 1'b0;
				end
				store_fill = 0;
				probe_num  = '0;
				ovf_sticky = 1'b0;
			end
			default: begin
				// The unused code is ignored: no beat, no change of state.
			end
		endcase
	endfunction

	function automatic triple_t idx3(int h, int k, int l);
		triple_t t;
		t.h = IDX_W'(h);
		t.k = IDX_W'(k);
		t.l = IDX_W'(l);
		return t;
	endfunction

	// Mostly full-range components. One time in four they come from a narrow
	// window, so that independent draws collide into equal keys.
	function automatic triple_t random_triple();
		triple_t t;
		if ($urandom_range(0, 3) == 0) begin
			t.h = IDX_W'($urandom_range(0, 3) - 2);
			t.k = IDX_W'($urandom_range(0, 3) - 2);
			t.l = IDX_W'($urandom_range(0, 3) - 2);
		end else begin
			t.h = IDX_W'($urandom);
			t.k = IDX_W'($urandom);
			t.l = IDX_W'($urandom);
		end
		return t;
	endfunction

	function automatic void send(req_e_t req, triple_t t, bit after_drain = 1'b0);
		request_t rq;
		rq.req         = req;
		rq.idx         = t;
		rq.after_drain = after_drain;
		requests_to_send = {requests_to_send, rq};
		if (req != REQ_NONE) begin
			queued++;
		end
	endfunction

	// Sender. It changes the inputs only at the falling edge. A beat that is
	// offered stays on the port unchanged until the monitor has seen it taken.
	// Bursts of random length alternate with random gaps, and now and then a
	// long burst with no gap at all gives the block back-to-back beats.
	int burst_left = 0;
	int gap_left   = 0;

	always @(negedge clk) begin : drive
		request_t nxt;
		logic     offer;
		if (arst_n && (!in_valid || in_taken)) begin
			in_taken = 1'b0;
			offer    = 1'b0;
			nxt      = '0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (requests_to_send.size() != 0 &&
				(!requests_to_send[0].after_drain || join_results_due.size() == 0)) begin
				nxt   = requests_to_send.pop_front();
				offer = 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
						: $urandom_range(1, 8);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
				end
			end
			in_valid <= offer;
			if (offer) begin
				on_port = nxt;
				req_type <= nxt.req;
				idx_h    <= nxt.idx.h;
				idx_k    <= nxt.idx.k;
				idx_l    <= nxt.idx.l;
			end
		end
	end

	// Receiver. It drives its stall from a pattern that it picks anew at random:
	// no stall, a coin toss, a fixed repeating stall pattern, or mostly
	// stalled. Once, after HOLD_BEAT result beats, it holds off for the whole
	// HOLD_LEN stretch. The sender keeps offering during that stretch, so
	// the block backs up and stalls its own input.
	rx_pattern_t rx_mode   = RX_FREE;
	int          rx_left   = 0;
	int          rx_tick   = 0;
	int          hold_left = 0;
	bit          hold_done = 1'b0;

	always @(negedge clk) begin : receive
		logic stall;
		rx_tick++;
		if (rx_left == 0) begin
			rx_mode = rx_pattern_t'($urandom_range(0, 3));
			rx_left = $urandom_range(16, 200);
		end else begin
			rx_left--;
		end
		if (!hold_done && out_beats >= HOLD_BEAT) begin
			hold_done = 1'b1;
			hold_left = HOLD_LEN;
		end
		if (hold_left > 0) begin
			hold_left--;
			stall = 1'b1;
		end else begin
			case (rx_mode)
				RX_FREE:          stall = 1'b0;
				RX_COIN:          stall = ($urandom_range(0, 1) == 0);
				RX_THREE_OF_FOUR: stall = (rx_tick % 4) != 0;
				default:          stall = ($urandom_range(0, 7) != 0);
			endcase
		end
		out_stall <= stall;
	end

	// Monitor. It samples at the rising edge. The output beat is checked before
	// any input beat of the same edge is predicted, so a new prediction can never
	// stand in for an older one. The watchdog ends the run once neither side
	// has moved a beat for the IDLE_LIMIT stretch.
	always @(posedge clk) begin : observe
		join_beat_t want;
		bit         moved;
		moved = 1'b0;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				moved = 1'b1;
				out_beats++;
				if (join_results_due.size() == 0) begin
					$error("result beat with nothing expected: kind %0d", kind);
					errors++;
				end else begin
					want = join_results_due.pop_front();
					if (kind !== want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, kind);
						errors++;
					end
					if (first_number !== want.first) begin
						$error("first_number: expected %0d, got %0d", want.first,
							first_number);
						errors++;
					end
					if (second_number !== want.second) begin
						$error("second_number: expected %0d, got %0d", want.second,
							second_number);
						errors++;
					end
					if (overflow !== want.ovf) begin
						$error("overflow: expected %0d, got %0d", want.ovf, overflow);
						errors++;
					end
					if (last !== want.lst) begin
						$error("last: expected %0d, got %0d", want.lst, last);
						errors++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				match_and_emit(on_port);
				in_taken = 1'b1;
				moved    = 1'b1;
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin : run
		triple_t t;
		triple_t top_key;
		triple_t seq_keys [$];
		int      n_load;
		int      n_probe;
		int      rand_base;
		int      i;

		// Directed opening. Flush and probe on an empty store, then loads at the
		// field extremes with one key loaded twice, and a beat of the unused code.
		// The probes that follow hit the later copy of the duplicate, hit entries
		// at both ends, and miss. The flush then returns the unmatched entries,
		// the earlier copy of the duplicate among them. Last, a set whose every
		// entry gets matched makes the flush report that nothing is left.
		send(REQ_FLUSH, idx3(0, 0, 0));
		send(REQ_PROBE, idx3(0, 0, 0));
		send(REQ_LOAD,  idx3(-512, -512, -512));
		send(REQ_LOAD,  idx3(511, 511, 511));
		send(REQ_LOAD,  idx3(0, 0, 0));
		send(REQ_LOAD,  idx3(-1, 0, 1));
		send(REQ_LOAD,  idx3(511, 511, 511));
		send(REQ_LOAD,  idx3(-512, 511, -1));
		send(REQ_NONE,  idx3(511, -512, -1));
		send(REQ_PROBE, idx3(511, 511, 511));
		send(REQ_PROBE, idx3(-512, -512, -512));
		send(REQ_PROBE, idx3(511, -512, 0));
		send(REQ_PROBE, idx3(-512, 511, -1));
		send(REQ_PROBE, idx3(-1, 0, 1));
		send(REQ_FLUSH, idx3(-1, -1, -1));
		send(REQ_LOAD,  idx3(85, -86, 170));
		send(REQ_PROBE, idx3(85, -86, 170));
		send(REQ_FLUSH, idx3(341, -342, 0));
		send(REQ_NONE,  idx3(-1, -1, -1));

		// Fill the store to the last entry, then push two more loads into a full
		// store. Probes must see the overflow flag, and so must the long flush
		// that follows. The probe after the flush shows the flag cleared and the
		// probe count back at zero. The sender holds the first load back until
		// the directed beats have all come out.
		top_key = '0;
		for (i = 0; i < DEPTH + 2; i++) begin
			t = random_triple();
			if (i == DEPTH - 1) begin
				top_key = t;
			end
			send(REQ_LOAD, t, i == 0);
		end
		send(REQ_PROBE, top_key);
		send(REQ_PROBE, random_triple());
		send(REQ_FLUSH, random_triple());
		send(REQ_PROBE, random_triple());

		// Saturating the probe counter takes 2**PROBE_BITS probes, each one a walk
		// down the whole row, far more than this run can afford. Only the predictor
		// covers that case.

		// Random part: load-probe-flush sets with random content. Loads repeat an
		// earlier key of the set now and then, and most probes reuse a loaded
		// key. Beats of the unused code are scattered in as noise. About one set
		// in six skips its flush, so the store carries over and can overflow.
		rand_base = queued;
		while (queued - rand_base < RAND_ITEMS) begin
			seq_keys.delete();
			n_load  = ($urandom_range(0, 7) == 0) ? $urandom_range(24, DEPTH + 3)
				: $urandom_range(0, 10);
			n_probe = $urandom_range(1, 12);
			for (i = 0; i < n_load; i++) begin
				if (seq_keys.size() != 0 && $urandom_range(0, 4) == 0) begin
					t = seq_keys[$urandom_range(0, seq_keys.size() - 1)];
				end else begin
					t = random_triple();
				end
				seq_keys = {seq_keys, t};
				send(REQ_LOAD, t, i == 0 && $urandom_range(0, 5) == 0);
			end
			for (i = 0; i < n_probe; i++) begin
				if ($urandom_range(0, 9) == 0) begin
					send(REQ_NONE, random_triple());
				end
				if (seq_keys.size() != 0 && $urandom_range(0, 9) < 7) begin
					t = seq_keys[$urandom_range(0, seq_keys.size() - 1)];
				end else begin
					t = random_triple();
				end
				send(REQ_PROBE, t);
			end
			if ($urandom_range(0, 5) != 0) begin
				send(REQ_FLUSH, random_triple());
			end
		end
		send(REQ_FLUSH, random_triple());

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Drain. A result that never arrives leaves the watchdog to end the run.
		while (requests_to_send.size() != 0 || in_valid) @(posedge clk);
		while (join_results_due.size() != 0) @(posedge clk);
		// Any stray beat still in the pipe shows up as unexpected in this window.
		repeat (2 * DEPTH + 8) @(posedge clk);

		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
